// ===== src/vfe_pkg.sv =====
// ----------------------------------------------------------------------------
// vfe_pkg
// shared types and constants for the volume fade and effect timer block
// ----------------------------------------------------------------------------
package vfe_pkg;

  localparam int unsigned DefChannels = 4;
  localparam int unsigned MaxChannels = 8;

  localparam logic [7:0] FadeSpeedRst = 8'd12;
  localparam logic [2:0] VolMax       = 3'd7;
  localparam logic [2:0] VolMin       = 3'd0;

  // event codes
  typedef enum logic [2:0] {
    EV_TICK     = 3'd0,
    EV_FADE_OUT = 3'd1,
    EV_FADE_IN  = 3'd2,
    EV_SET_VOL  = 3'd3,
    EV_MUTE_ON  = 3'd4,
    EV_MUTE_OFF = 3'd5,
    EV_EFFECT   = 3'd6
  } ev_kind_e;

  // fade state machine, one-hot
  typedef enum logic [3:0] {
    FADE_IDLE = 4'b0001,
    FADE_DOWN = 4'b0010,
    FADE_UP   = 4'b0100,
    FADE_PEND = 4'b1000
  } fade_mode_e;

  // reported fade state codes
  localparam logic [1:0] FsIdle = 2'd0;
  localparam logic [1:0] FsDown = 2'd1;
  localparam logic [1:0] FsUp   = 2'd2;
  localparam logic [1:0] FsPend = 2'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] volume_value;
    logic [1:0] effect_channel;
    logic [7:0] effect_ticks;
  } vfe_event_t;

  typedef struct packed {
    logic [2:0] master_volume;
    logic [6:0] mixer_level;
    logic       sound_power;
    logic [3:0] music_play_mask;
    logic [1:0] fade_state;
  } vfe_status_t;

  function automatic logic [1:0] fade_code(fade_mode_e m);
    logic [1:0] code;
    unique case (m)
      FADE_IDLE: code = FsIdle;
      FADE_DOWN: code = FsDown;
      FADE_UP:   code = FsUp;
      FADE_PEND: code = FsPend;
      default:   code = FsIdle;
    endcase
    return code;
  endfunction

endpackage

// ===== src/volume_fade_and_effect_timers_top.sv =====
// ----------------------------------------------------------------------------
// volume_fade_and_effect_timers_top
// master volume fader, mute control and per-channel effect hold timers
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                payload
//   -------  ---------  -----------------------  ---------------------------------
//   event    in         in_valid_i / in_stall_o  kind, volume_value, effect_*
//   result   out        out_valid_o / out_stall_i master_volume, mixer_level,
//                                                sound_power, music_play_mask,
//                                                fade_state
//   config   in         cfg_we_i                 cfg_wdata_i -> fade step period
//
// one event per cycle sustained while the receiver does not stall; a result is
// captured into the result register by the state update once its event sits in
// the input register and the result side can move
// reset restores volume 7, fade idle, power on, all channels playing and a
// fade step period of 12; no clearing pass is needed
// a stalled result holds the result register, and the input register keeps
// taking events until it too is full
//
module volume_fade_and_effect_timers_top import vfe_pkg::*; #(
  parameter int unsigned CHANNELS = DefChannels
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // event channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] kind_i,
  input  logic [2:0] volume_value_i,
  input  logic [1:0] effect_channel_i,
  input  logic [7:0] effect_ticks_i,
  // configuration
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] master_volume_o,
  output logic [6:0] mixer_level_o,
  output logic       sound_power_o,
  output logic [3:0] music_play_mask_o,
  output logic [1:0] fade_state_o
);

  logic        adv;          // result register can take a new item
  logic        ev_valid;
  logic        fire;         // engine commits one event this cycle
  vfe_event_t  in_event;
  vfe_event_t  ev;
  vfe_status_t status;
  vfe_status_t res_q;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  step_period_q;

  assign in_event.kind           = kind_i;
  assign in_event.volume_value   = volume_value_i;
  assign in_event.effect_channel = effect_channel_i;
  assign in_event.effect_ticks   = effect_ticks_i;

  // fade prescaler reload value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_period_q <= FadeSpeedRst;
    end else if (cfg_we_i) begin
      step_period_q <= cfg_wdata_i;
    end
  end

  vfe_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_event_i (in_event),
    .adv_i      (adv),
    .ev_valid_o (ev_valid),
    .ev_o       (ev)
  );

  // the engine steps exactly when it holds an event and its result has a place to go
  assign adv  = ~out_valid_q | ~out_stall_i;
  assign fire = ev_valid & adv;

  vfe_engine #(
    .CHANNELS (CHANNELS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .ev_i          (ev),
    .step_period_i (step_period_q),
    .status_o      (status)
  );

  // result register
  assign out_valid_d = adv ? ev_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= status;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign master_volume_o   = res_q.master_volume;
  assign mixer_level_o     = res_q.mixer_level;
  assign sound_power_o     = res_q.sound_power;
  assign music_play_mask_o = res_q.music_play_mask;
  assign fade_state_o      = res_q.fade_state;

endmodule

// ===== src/vfe_in_stage.sv =====
// ----------------------------------------------------------------------------
// vfe_in_stage
// input register: captures one event transfer and holds it for the engine
// ----------------------------------------------------------------------------
module vfe_in_stage import vfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  vfe_event_t in_event_i,
  input  logic       adv_i,
  output logic       ev_valid_o,
  output vfe_event_t ev_o
);

  logic       valid_q, valid_d;
  vfe_event_t ev_q;

  // holds only while loaded and the result side cannot move
  assign in_stall_o = valid_q & ~adv_i;
  assign valid_d    = in_stall_o ? valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ev_q <= in_event_i;
    end
  end

  assign ev_valid_o = valid_q;
  assign ev_o       = ev_q;

endmodule

// ===== src/vfe_engine.sv =====
// ----------------------------------------------------------------------------
// vfe_engine
// volume, fade and effect hold state with its per-event update logic
// ----------------------------------------------------------------------------
module vfe_engine import vfe_pkg::*; #(
  parameter int unsigned CHANNELS = DefChannels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  vfe_event_t  ev_i,
  input  logic [7:0]  step_period_i,
  output vfe_status_t status_o
);

  localparam logic [MaxChannels-1:0] ChMask = MaxChannels'((1 << CHANNELS) - 1);

  logic [2:0]          vol_q, vol_d;
  fade_mode_e          mode_q, mode_d;
  logic [7:0]          fcnt_q, fcnt_d;
  logic                poff_q, poff_d;
  logic [7:0]          ecnt_q [CHANNELS];
  logic [7:0]          ecnt_d [CHANNELS];
  logic [CHANNELS-1:0] held_q, held_d;

  logic [7:0]             fcnt_dec;
  logic [2:0]             vol_step;
  logic                   skip;
  logic [MaxChannels-1:0] play;

  assign fcnt_dec = fcnt_q - 8'd1;

  always_comb begin
    vol_d    = vol_q;
    mode_d   = mode_q;
    fcnt_d   = fcnt_q;
    poff_d   = poff_q;
    ecnt_d   = ecnt_q;
    held_d   = held_q;
    skip     = 1'b0;
    vol_step = vol_q;
    case (ev_kind_e'(ev_i.kind))
      EV_TICK: begin
        if (mode_q != FADE_IDLE) begin
          fcnt_d = fcnt_dec;
          if (fcnt_dec == 8'd0) begin
            fcnt_d = step_period_i;
            unique case (mode_q)
              FADE_UP: begin
                vol_step = (vol_q < VolMax) ? vol_q + 3'd1 : vol_q;
                vol_d    = vol_step;
                if (vol_step == VolMax) begin
                  mode_d = FADE_IDLE;
                  skip   = 1'b1;
                end
              end
              FADE_DOWN: begin
                vol_step = (vol_q > VolMin) ? vol_q - 3'd1 : vol_q;
                vol_d    = vol_step;
                if (vol_step == VolMin) begin
                  mode_d = FADE_PEND;
                  skip   = 1'b1;
                end
              end
              FADE_PEND: begin
                mode_d = FADE_IDLE;
                poff_d = 1'b1;
                skip   = 1'b1;
              end
              default: begin
                mode_d = FADE_IDLE;
              end
            endcase
          end
        end
        // channel countdowns run only when no fade step ended a fade or muted this tick
        if (!skip) begin
          for (int c = 0; c < int'(CHANNELS); c++) begin
            if (ecnt_q[c] != 8'd0) begin
              ecnt_d[c] = ecnt_q[c] - 8'd1;
            end else begin
              held_d[c] = 1'b0;
            end
          end
        end
      end
      EV_FADE_OUT: begin
        if (vol_q != VolMin) begin
          mode_d = FADE_DOWN;
          fcnt_d = step_period_i;
        end
      end
      EV_FADE_IN: begin
        if (vol_q != VolMax) begin
          mode_d = FADE_UP;
          fcnt_d = step_period_i;
        end
      end
      EV_SET_VOL:  vol_d  = ev_i.volume_value;
      EV_MUTE_ON:  poff_d = 1'b1;
      EV_MUTE_OFF: poff_d = 1'b0;
      EV_EFFECT: begin
        // channels past the configured count match no slot and are ignored
        for (int c = 0; c < int'(CHANNELS); c++) begin
          if (int'(ev_i.effect_channel) == c) begin
            held_d[c] = 1'b1;
            ecnt_d[c] = ev_i.effect_ticks;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q  <= VolMax;
      mode_q <= FADE_IDLE;
      fcnt_q <= 8'd0;
      poff_q <= 1'b0;
      held_q <= '0;
      for (int c = 0; c < int'(CHANNELS); c++) begin
        ecnt_q[c] <= 8'd0;
      end
    end else if (fire_i) begin
      vol_q  <= vol_d;
      mode_q <= mode_d;
      fcnt_q <= fcnt_d;
      poff_q <= poff_d;
      held_q <= held_d;
      ecnt_q <= ecnt_d;
    end
  end

  assign play = ~MaxChannels'(held_d) & ChMask;

  assign status_o.master_volume   = vol_d;
  assign status_o.mixer_level     = {vol_d, 1'b0, vol_d};
  assign status_o.sound_power     = ~poff_d;
  assign status_o.music_play_mask = play[3:0];
  assign status_o.fade_state      = fade_code(mode_d);

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives events into the volume fade and effect timer block, predicts every
// status word in a tracking model of volume, fade, power and channel holds,
// and checks each result transfer in order against that prediction
// ----------------------------------------------------------------------------
module testbench import vfe_pkg::*;;

  // kind code the block does not define; it must only report the status
  localparam logic [2:0] EvUnused = 3'd7;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned SettleCycles = 6;   // two-stage pipe plus margin
  localparam int unsigned HoldCycles   = 48;  // long receiver hold-off

  // --------------------------------------------------------------------------
  // status tracker: mirrors the block state and queues the status words
  // that the block owes, one per accepted event
  // --------------------------------------------------------------------------
  class fade_status_book;
    logic [7:0]  speed;
    logic [2:0]  vol;
    logic [1:0]  fading;
    logic [7:0]  prescale;
    logic        muted;
    logic [7:0]  hold_count [DefChannels];
    logic [3:0]  held;
    vfe_status_t due [$];
    int unsigned errors;

    function new();
      speed    = FadeSpeedRst;
      vol      = VolMax;
      fading   = FsIdle;
      prescale = 8'd0;
      muted    = 1'b0;
      held     = '0;
      errors   = 0;
      foreach (hold_count[c]) hold_count[c] = 8'd0;
    endfunction

    function void set_speed(logic [7:0] value);
      speed = value;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    // one prescaler tick; returns 1 when a fade step ends the fade or mutes,
    // in which case the channel countdowns sit this tick out
    function bit advance_fade();
      if (fading == FsIdle) return 1'b0;
      prescale = prescale - 8'd1;
      if (prescale != 8'd0) return 1'b0;
      prescale = speed;
      if (fading == FsUp) begin
        if (vol < VolMax) vol = vol + 3'd1;
        if (vol == VolMax) begin
          fading = FsIdle;
          return 1'b1;
        end
      end else if (fading == FsDown) begin
        if (vol > VolMin) vol = vol - 3'd1;
        if (vol == VolMin) begin
          fading = FsPend;
          return 1'b1;
        end
      end else begin
        fading = FsIdle;
        muted  = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_event(vfe_event_t ev);
      vfe_status_t st;
      case (ev.kind)
        EV_TICK: begin
          if (!advance_fade()) begin
            for (int c = 0; c < DefChannels; c++) begin
              if (hold_count[c] != 8'd0) hold_count[c] = hold_count[c] - 8'd1;
              else held[c] = 1'b0;
            end
          end
        end
        EV_FADE_OUT: begin
          if (vol != VolMin) begin
            fading   = FsDown;
            prescale = speed;
          end
        end
        EV_FADE_IN: begin
          if (vol != VolMax) begin
            fading   = FsUp;
            prescale = speed;
          end
        end
        EV_SET_VOL:  vol   = ev.volume_value;
        EV_MUTE_ON:  muted = 1'b1;
        EV_MUTE_OFF: muted = 1'b0;
        EV_EFFECT: begin
          held[ev.effect_channel]       = 1'b1;
          hold_count[ev.effect_channel] = ev.effect_ticks;
        end
        default: ;
      endcase
      st.master_volume   = vol;
      st.mixer_level     = 7'(vol) | (7'(vol) << 4);
      st.sound_power     = ~muted;
      st.music_play_mask = ~held;
      st.fade_state      = fading;
      due.push_back(st);
    endfunction

    function void field_ok(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_status(vfe_status_t got);
      vfe_status_t want;
      if (due.size() == 0) begin
        $display("%0t: status %h arrived with no transfer outstanding", $time, got);
        errors++;
        return;
      end
      want = due.pop_front();
      field_ok("master_volume", 8'(want.master_volume), 8'(got.master_volume));
      field_ok("mixer_level", 8'(want.mixer_level), 8'(got.mixer_level));
      field_ok("sound_power", 8'(want.sound_power), 8'(got.sound_power));
      field_ok("music_play_mask", 8'(want.music_play_mask), 8'(got.music_play_mask));
      field_ok("fade_state", 8'(want.fade_state), 8'(got.fade_state));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [2:0] kind_i;
  logic [2:0] volume_value_i;
  logic [1:0] effect_channel_i;
  logic [7:0] effect_ticks_i;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] master_volume_o;
  logic [6:0] mixer_level_o;
  logic       sound_power_o;
  logic [3:0] music_play_mask_o;
  logic [1:0] fade_state_o;

  volume_fade_and_effect_timers_top uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .kind_i            (kind_i),
    .volume_value_i    (volume_value_i),
    .effect_channel_i  (effect_channel_i),
    .effect_ticks_i    (effect_ticks_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .master_volume_o   (master_volume_o),
    .mixer_level_o     (mixer_level_o),
    .sound_power_o     (sound_power_o),
    .music_play_mask_o (music_play_mask_o),
    .fade_state_o      (fade_state_o)
  );

  fade_status_book book;

  // random idling on both sides; cleared for the closing stretch
  bit jitter_on;
  // raised by the event driver to ask the receiver for one long hold-off
  bit hold_req;

  // clock, 8 time units per period
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run-away guard
  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("%0t: cycle limit reached", $time);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: checks each result transfer, then picks the stall for the
  // next cycle (random bursts, or the long hold-off when asked for)
  // --------------------------------------------------------------------------
  initial begin
    vfe_status_t got;
    int unsigned stall_left;
    out_stall_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.master_volume   = master_volume_o;
        got.mixer_level     = mixer_level_o;
        got.sound_power     = sound_power_o;
        got.music_play_mask = music_play_mask_o;
        got.fade_state      = fade_state_o;
        book.check_status(got);
      end
      if (stall_left == 0 && hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles;
      end else if (stall_left == 0 && jitter_on && $urandom_range(7) == 0) begin
        stall_left = $urandom_range(7, 1);
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // event driver tasks
  // --------------------------------------------------------------------------

  // offer one event and hold it until the transfer; may then idle a burst
  task automatic push_event(input vfe_event_t ev);
    in_valid_i       <= 1'b1;
    kind_i           <= ev.kind;
    volume_value_i   <= ev.volume_value;
    effect_channel_i <= ev.effect_channel;
    effect_ticks_i   <= ev.effect_ticks;
    do @(posedge clk_i); while (in_stall_o);
    book.note_event(ev);
    if (jitter_on && $urandom_range(7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk_i);
    end
  endtask

  task automatic put(input logic [2:0] kind, input logic [2:0] vol,
                     input logic [1:0] chan, input logic [7:0] ticks);
    vfe_event_t ev;
    ev.kind           = kind;
    ev.volume_value   = vol;
    ev.effect_channel = chan;
    ev.effect_ticks   = ticks;
    push_event(ev);
  endtask

  // stop offering and wait until the block owes nothing, then let it settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // fade speed write; only called with the block drained
  task automatic write_speed(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    book.set_speed(value);
  endtask

  // mostly ticks so fades and effect holds run to their ends; small effect
  // lengths keep holds expiring, with the full range now and then
  function automatic vfe_event_t random_event();
    vfe_event_t ev;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50)      ev.kind = EV_TICK;
    else if (r < 58) ev.kind = EV_FADE_OUT;
    else if (r < 66) ev.kind = EV_FADE_IN;
    else if (r < 73) ev.kind = EV_SET_VOL;
    else if (r < 78) ev.kind = EV_MUTE_ON;
    else if (r < 84) ev.kind = EV_MUTE_OFF;
    else if (r < 98) ev.kind = EV_EFFECT;
    else             ev.kind = EvUnused;
    ev.volume_value   = 3'($urandom_range(7));
    ev.effect_channel = 2'($urandom_range(3));
    if ($urandom_range(3) == 0) ev.effect_ticks = 8'($urandom_range(255));
    else                        ev.effect_ticks = 8'($urandom_range(12));
    return ev;
  endfunction

  task automatic random_events(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) push_event(random_event());
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    book             = new();
    jitter_on        = 1'b1;
    hold_req         = 1'b0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    kind_i           = EV_TICK;
    volume_value_i   = '0;
    effect_channel_i = '0;
    effect_ticks_i   = '0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed walk with the fastest fade, one step per tick
    write_speed(8'd1);
    put(EvUnused,    3'd0, 2'd0, 8'd0);    // undefined kind reports reset status
    put(EV_SET_VOL,  3'd0, 2'd0, 8'd0);    // volume floor
    put(EV_FADE_OUT, 3'd0, 2'd0, 8'd0);    // no fade from silence
    put(EV_SET_VOL,  3'd6, 2'd0, 8'd0);
    put(EV_FADE_IN,  3'd0, 2'd0, 8'd0);
    put(EV_EFFECT,   3'd0, 2'd3, 8'd255);  // longest hold on the top channel
    put(EV_EFFECT,   3'd0, 2'd0, 8'd0);    // zero-length hold
    put(EV_TICK,     3'd0, 2'd0, 8'd0);    // fade-in reaches 7, countdowns skipped
    put(EV_TICK,     3'd0, 2'd0, 8'd0);    // zero-length hold released here
    put(EV_FADE_IN,  3'd0, 2'd0, 8'd0);    // already at full volume
    put(EV_SET_VOL,  3'd1, 2'd0, 8'd0);
    put(EV_FADE_OUT, 3'd0, 2'd0, 8'd0);
    put(EV_TICK,     3'd0, 2'd0, 8'd0);    // reaches 0, final mute pending
    put(EV_TICK,     3'd0, 2'd0, 8'd0);    // final mute powers off
    put(EV_MUTE_OFF, 3'd0, 2'd0, 8'd0);
    put(EV_MUTE_ON,  3'd0, 2'd0, 8'd0);
    put(EV_MUTE_OFF, 3'd0, 2'd0, 8'd0);
    put(EV_SET_VOL,  3'd7, 2'd0, 8'd0);    // volume ceiling
    put(EV_EFFECT,   3'd0, 2'd1, 8'd1);
    put(EV_EFFECT,   3'd0, 2'd2, 8'd170);
    put(EV_TICK,     3'd0, 2'd0, 8'd0);
    put(EV_TICK,     3'd0, 2'd0, 8'd0);
    put(EvUnused,    3'd7, 2'd3, 8'd255);  // undefined kind with every field bit set
    put(EV_FADE_OUT, 3'd0, 2'd0, 8'd0);
    put(EV_TICK,     3'd0, 2'd0, 8'd0);
    drain();

    // longest nonzero prescaler reload
    write_speed(8'd255);
    random_events(100);
    drain();

    // zero reload: prescaler wraps and counts a full 256
    write_speed(8'd0);
    random_events(120);
    drain();

    // quick fades; receiver holds off long while events keep coming so the
    // input side backs up and stalls
    write_speed(8'd2);
    hold_req = 1'b1;
    random_events(400);
    drain();

    // moderate speed; sender pauses mid-phase until everything is back
    write_speed(8'($urandom_range(6, 3)));
    random_events(150);
    drain();
    random_events(150);
    drain();

    // closing stretch at full rate, no idling on either side
    write_speed(8'd5);
    jitter_on = 1'b0;
    random_events(450);
    drain();

    if (book.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
